FILE: rtl/core/ama_pkg.sv
`default_nettype none

package ama_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned RANGE_W     = 2;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  // Default ring depth
  localparam int unsigned WINDOW_DEF = 16;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD  = 2'd2;

  // Configuration reset values
  localparam logic [SAMPLE_W-1:0] UPPER_RST = 24'd15728640;
  localparam logic [SAMPLE_W-1:0] LOWER_RST = 24'd1048576;

  // Range codes
  localparam logic [RANGE_W-1:0] BAND_LOW  = 2'd0;
  localparam logic [RANGE_W-1:0] BAND_MID  = 2'd1;
  localparam logic [RANGE_W-1:0] BAND_HIGH = 2'd2;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/ama_ram.sv
`default_nettype none

module ama_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/ama_div.sv
`default_nettype none

module ama_div
  import ama_pkg::*;
#(
  parameter int unsigned DIVIDEND_W = 28,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic      [DIVIDEND_W-1:0] quotient_o,
  output div_stat_t                  stat_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/autoranging_moving_average.sv
// Channel   Dir  Fields (tdata, low bit up)
// s_axis    in   sample[23:0]
// m_axis    out  average[23:0], range_sel[25:24], range_changed[26], zero[31:27]
// cfg       in   0 upper_threshold, 1 lower_threshold, 2 hold_history
//
// Each word's average comes from the bit-serial divider that forms sum / fill
// count, one quotient bit a cycle.
// s_axis_tready is high only while the sequencer idles; a finished word waits
// in the output register and the next sample is taken meanwhile.
// Reset leaves the ring empty (fill count zero) and the range at mid; the ring
// RAM itself is not cleared.
`default_nettype none

module autoranging_moving_average
  import ama_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // sample
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // average, range_sel, range_changed, zero pad
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [SAMPLE_W-1:0]    cfg_wdata_i
);

  localparam int unsigned POS_W = $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [SAMPLE_W-1:0] upper_q, lower_q;
  logic                hold_q;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [RANGE_W-1:0]  range_q, range_d;
  logic [SAMPLE_W-1:0] sample_q;
  logic                m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic [SAMPLE_W-1:0] old_entry;
  logic [SUM_W-1:0]    quotient;
  div_stat_t           div_stat;
  logic                div_start;
  logic                ring_full;
  logic                accept;
  logic                out_free;
  logic [SAMPLE_W-1:0] avg;
  logic                step_up, step_dn, changed;
  logic [RANGE_W-1:0]  range_new;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign ring_full     = (fill_q == CNT_W'(WINDOW));
  assign out_free      = !m_valid_q || m_axis_tready;
  assign div_start     = (state_q == ST_UPD);
  assign avg           = quotient[SAMPLE_W-1:0];

  // Ring storage; the oldest entry is read at the write position
  ama_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_UPD),
    .waddr_i (pos_q),
    .wdata_i (sample_q),
    .raddr_i (pos_q),
    .rdata_o (old_entry)
  );

  // Serial divider: running sum / fill count
  ama_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // Range decision; step up wins when both thresholds are crossed
  always_comb begin
    step_up   = (range_q != BAND_HIGH) && (avg > upper_q);
    step_dn   = !step_up && (range_q != BAND_LOW) && (avg < lower_q);
    changed   = step_up || step_dn;
    range_new = range_q;
    if (step_up) begin
      range_new = range_q + 1'b1;
    end else if (step_dn) begin
      range_new = range_q - 1'b1;
    end
  end

  // Sequencer and history update
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    fill_d    = fill_q;
    sum_d     = sum_q;
    range_d   = range_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        // old entry leaves the sum only when the ring is full
        if (ring_full) begin
          sum_d = sum_q - SUM_W'(old_entry) + SUM_W'(sample_q);
        end else begin
          sum_d  = sum_q + SUM_W'(sample_q);
          fill_d = fill_q + 1'b1;
        end
        pos_d   = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          range_d   = range_new;
          m_valid_d = 1'b1;
          m_data_d  = {{(OUT_TDATA_W - SAMPLE_W - RANGE_W - 1){1'b0}},
                       changed, range_new, avg};
          if (changed && !hold_q) begin
            pos_d  = '0;
            fill_d = '0;
            sum_d  = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
      range_q   <= BAND_MID;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      fill_q    <= fill_d;
      sum_q     <= sum_d;
      range_q   <= range_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UPPER_RST;
      lower_q <= LOWER_RST;
      hold_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UPPER: upper_q <= cfg_wdata_i;
        REG_LOWER: lower_q <= cfg_wdata_i;
        REG_HOLD:  hold_q  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= s_axis_tdata[SAMPLE_W-1:0];
    end
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Checks
  a_ready_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide state");

  a_accept_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_UPD) && div_stat.busy == 1'b0)
    else $error("accepted word did not start an update");

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import ama_pkg::*;

  localparam int unsigned DEPTH         = WINDOW_DEF;
  localparam int unsigned POS_W         = $clog2(DEPTH);
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_WORDS   = 200;
  localparam int unsigned NUM_PHASES    = 8;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [RANGE_W-1:0]  range_sel;
    logic                range_changed;
  } avg_word_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // sample[23:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // average[23:0], range_sel[25:24], range_changed[26], zero[31:27]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [SAMPLE_W-1:0]    cfg_wdata_i   = '0;

  // stimulus and scoreboard
  logic [SAMPLE_W-1:0] pending_samples [$];
  avg_word_t           expected_averages [$];
  int unsigned         words_to_send  = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         quiet_cycles   = 0;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;

  // filter state as predicted
  logic [SAMPLE_W-1:0]       ring [DEPTH];
  logic [POS_W-1:0]          ring_pos  = '0;
  logic [POS_W:0]            ring_fill = '0;
  logic [SAMPLE_W+POS_W-1:0] ring_sum  = '0;
  logic [RANGE_W-1:0]        cur_range = BAND_MID;
  logic [SAMPLE_W-1:0]       upper_thr = UPPER_RST;
  logic [SAMPLE_W-1:0]       lower_thr = LOWER_RST;
  logic                      hold_hist = 1'b0;

  autoranging_moving_average i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Ring update, mean and range step for one accepted sample
  task automatic predict_average(input logic [SAMPLE_W-1:0] smp);
    avg_word_t w;
    // oldest entry leaves the sum once the ring is full
    if (ring_fill == DEPTH) ring_sum -= ring[ring_pos];
    ring[ring_pos] = smp;
    ring_sum += smp;
    ring_pos += 1'b1;
    if (ring_fill < DEPTH) ring_fill += 1'b1;
    w.average       = SAMPLE_W'(ring_sum / ring_fill);
    w.range_changed = 1'b0;
    // step up wins when both thresholds are crossed
    if (cur_range < BAND_HIGH && w.average > upper_thr) begin
      cur_range += 1'b1;
      w.range_changed = 1'b1;
    end else if (cur_range > BAND_LOW && w.average < lower_thr) begin
      cur_range -= 1'b1;
      w.range_changed = 1'b1;
    end
    w.range_sel = cur_range;
    // restart after the word is formed unless history is held
    if (w.range_changed && !hold_hist) begin
      ring_pos  = '0;
      ring_fill = '0;
      ring_sum  = '0;
    end
    expected_averages.push_back(w);
  endtask

  task automatic queue_sample(input logic [SAMPLE_W-1:0] smp);
    pending_samples.push_back(smp);
    words_to_send++;
  endtask

  // Runs of samples around a level, so averages settle and cross thresholds,
  // with some full-range noise mixed in
  task automatic queue_random(input int unsigned count);
    int unsigned n;
    int unsigned pick;
    int unsigned run_len;
    longint      level;
    longint      spread;
    longint      val;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 20) level = $urandom_range(32'h0F_FFFF);
      else if (pick < 40) level = $urandom_range(32'hFF_FFFF, 32'hF0_0000);
      else level = $urandom_range(32'hFF_FFFF);
      spread  = $urandom_range(1 << $urandom_range(20));
      run_len = $urandom_range(40, 1);
      for (int i = 0; i < run_len && n < count; i++) begin
        if ($urandom_range(9) == 0) begin
          val = $urandom_range(32'hFF_FFFF);
        end else begin
          val = level - spread + $urandom_range(2 * spread);
          if (val < 0) val = 0;
          if (val > FULL_SCALE) val = FULL_SCALE;
        end
        queue_sample(SAMPLE_W'(val));
        n++;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_UPPER: upper_thr = val;
      REG_LOWER: lower_thr = val;
      REG_HOLD:  hold_hist = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [SAMPLE_W-1:0] upper, input logic [SAMPLE_W-1:0] lower,
                           input logic hold);
    write_reg(REG_UPPER, upper);
    write_reg(REG_LOWER, lower);
    write_reg(REG_HOLD, {{(SAMPLE_W-1){1'b0}}, hold});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every word is sent and answered, then let the block settle
  task automatic drain();
    while (words_to_send != 0 || expected_averages.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Source side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_average(s_axis_tdata[SAMPLE_W-1:0]);
        words_to_send--;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered word
      end else if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_samples.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink side and word check
  always @(posedge clk_i) begin : check_words
    avg_word_t exp_w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_averages.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          exp_w = expected_averages.pop_front();
          if (m_axis_tdata[SAMPLE_W-1:0] !== exp_w.average) begin
            $display("%0t: average expected %h actual %h", $time, exp_w.average,
                     m_axis_tdata[SAMPLE_W-1:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[SAMPLE_W +: RANGE_W] !== exp_w.range_sel) begin
            $display("%0t: range_sel expected %0d actual %0d", $time, exp_w.range_sel,
                     m_axis_tdata[SAMPLE_W +: RANGE_W]);
            mismatch_count++;
          end
          if (m_axis_tdata[SAMPLE_W+RANGE_W] !== exp_w.range_changed) begin
            $display("%0t: range_changed expected %b actual %b", $time, exp_w.range_changed,
                     m_axis_tdata[SAMPLE_W+RANGE_W]);
            mismatch_count++;
          end
          if (m_axis_tdata[OUT_TDATA_W-1:SAMPLE_W+RANGE_W+1] !== '0) begin
            $display("%0t: pad expected 0 actual %h", $time,
                     m_axis_tdata[OUT_TDATA_W-1:SAMPLE_W+RANGE_W+1]);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("autoranging_moving_average: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: mid to low, then up through mid to high, stay at high
    queue_sample('0);
    queue_sample(FULL_SCALE);
    queue_sample(FULL_SCALE);
    queue_sample(FULL_SCALE);
    // alternating bit patterns fill and wrap the ring
    for (int i = 0; i < 18; i++) queue_sample((i % 2) ? 24'h55_5555 : 24'hAA_AAAA);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: configure(FULL_SCALE, '0, 1'b0);                  // range never moves
        2: configure('0, FULL_SCALE, 1'b1);                  // both thresholds crossed
        3: configure(24'hC0_0000, 24'h40_0000, 1'b1);
        4, 6: configure(SAMPLE_W'($urandom_range(32'hFF_FFFF)),
                        SAMPLE_W'($urandom_range(32'hFF_FFFF)),
                        1'($urandom_range(1)));
        5: configure('0, '0, 1'b0);                          // any nonzero mean steps up
        7: configure(FULL_SCALE, FULL_SCALE, 1'b0);          // walks down and sits at low
        default: ;
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      queue_random(PHASE_WORDS);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("autoranging_moving_average: match");
    end else begin
      $display("autoranging_moving_average: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ama_pkg.sv
rtl/core/ama_ram.sv
rtl/core/ama_div.sv
rtl/core/autoranging_moving_average.sv
verif/tb.sv
